// ----- hdl/subb_pkg.sv -----
// ----------------------------------------------------------------------------
// subb_pkg
// Shared types, codes and coefficient tables for the stereo upmix biquad bank.
// ----------------------------------------------------------------------------
package subb_pkg;

  localparam int SAMPLE_W = 32;
  localparam int ACC_W    = 40;
  localparam int GAIN_W   = 31;
  localparam int PROD_W   = 64;
  localparam int HIST_D   = 12;
  localparam int NUM_CH   = 6;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROUTE_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INPUT_GAIN = 2'd1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 31'd1520301996;

  // filter sets
  localparam logic [1:0] SET_LPF = 2'd0;
  localparam logic [1:0] SET_HPF = 2'd1;
  localparam logic [1:0] SET_BPF = 2'd2;

  // channel numbers
  localparam logic [2:0] CH_LEFT   = 3'd0;
  localparam logic [2:0] CH_CENTER = 3'd1;
  localparam logic [2:0] CH_RIGHT  = 3'd2;
  localparam logic [2:0] CH_LSUR   = 3'd3;
  localparam logic [2:0] CH_RSUR   = 3'd4;
  localparam logic [2:0] CH_BASS   = 3'd5;

  // biquad term steps
  localparam logic [2:0] TERM_A0   = 3'd0;
  localparam logic [2:0] TERM_A1   = 3'd1;
  localparam logic [2:0] TERM_A2   = 3'd2;
  localparam logic [2:0] TERM_B1   = 3'd3;
  localparam logic [2:0] TERM_B2   = 3'd4;
  localparam logic [2:0] TERM_LAST = 3'd5;

  localparam logic [2:0] LAST_SLOT_PASS = 3'd4;
  localparam logic [2:0] LAST_SLOT_FULL = 3'd5;

  typedef struct packed {
    logic [2:0] ch;
    logic [1:0] set;
    logic       src_r;
  } slot_desc_t;

  typedef struct packed {
    logic       capture;
    logic       mul_en;
    logic       mul_gain;
    logic       mul_gain_r;
    logic [2:0] mul_term;
    slot_desc_t mul_desc;
    logic       tl_en;
    logic       tr_en;
    logic       pass_en;
    logic       acc_en;
    logic       acc_first;
    logic [2:0] acc_term;
    logic       wb_en;
    slot_desc_t wb_desc;
    logic       push_en;
  } dp_cmd_t;

  function automatic slot_desc_t slot_desc(input logic mode, input logic [2:0] slot);
    slot_desc_t d;
    d = '{ch: CH_LEFT, set: SET_LPF, src_r: 1'b0};
    if (mode) begin
      case (slot)
        3'd0: d = '{ch: CH_CENTER, set: SET_LPF, src_r: 1'b0};
        3'd1: d = '{ch: CH_LSUR,   set: SET_HPF, src_r: 1'b0};
        3'd2: d = '{ch: CH_RSUR,   set: SET_BPF, src_r: 1'b0};
        3'd3: d = '{ch: CH_RIGHT,  set: SET_BPF, src_r: 1'b1};
        3'd4: d = '{ch: CH_BASS,   set: SET_HPF, src_r: 1'b1};
        default: d = '{ch: CH_BASS, set: SET_HPF, src_r: 1'b1};
      endcase
    end else begin
      case (slot)
        3'd0: d = '{ch: CH_LEFT,   set: SET_LPF, src_r: 1'b0};
        3'd1: d = '{ch: CH_CENTER, set: SET_HPF, src_r: 1'b0};
        3'd2: d = '{ch: CH_LSUR,   set: SET_BPF, src_r: 1'b0};
        3'd3: d = '{ch: CH_RSUR,   set: SET_BPF, src_r: 1'b1};
        3'd4: d = '{ch: CH_RIGHT,  set: SET_HPF, src_r: 1'b1};
        3'd5: d = '{ch: CH_BASS,   set: SET_LPF, src_r: 1'b1};
        default: d = '{ch: CH_BASS, set: SET_LPF, src_r: 1'b1};
      endcase
    end
    return d;
  endfunction

  // halved coefficients, Q1.31
  function automatic logic signed [SAMPLE_W-1:0] coef(input logic [1:0] set,
                                                      input logic [2:0] term);
    logic signed [SAMPLE_W-1:0] c;
    c = '0;
    case (set)
      SET_LPF: begin
        case (term)
          TERM_A0: c = 32'sd610995363;
          TERM_A1: c = 32'sd1221990726;
          TERM_A2: c = 32'sd610995363;
          TERM_B1: c = 32'sd1012330264;
          TERM_B2: c = 32'sd357909365;
          default: c = '0;
        endcase
      end
      SET_HPF: begin
        case (term)
          TERM_A0: c = 32'sd997101531;
          TERM_A1: c = -32'sd1994203062;
          TERM_A2: c = 32'sd997101531;
          TERM_B1: c = -32'sd1988725833;
          TERM_B2: c = 32'sd925938467;
          default: c = '0;
        endcase
      end
      SET_BPF: begin
        case (term)
          TERM_A0: c = 32'sd399719220;
          TERM_A1: c = 32'sd0;
          TERM_A2: c = -32'sd399719220;
          TERM_B1: c = -32'sd734198042;
          TERM_B2: c = 32'sd274303384;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/subb_ctrl.sv -----
// ----------------------------------------------------------------------------
// subb_ctrl
// Sequencer: gain steps, five MAC steps per filter slot, writeback, output.
// ----------------------------------------------------------------------------
module subb_ctrl import subb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  input  logic    route_mode,
  output dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GAIN = 5'b00010,
    S_RUN  = 5'b00100,
    S_WB   = 5'b01000,
    S_PUSH = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic       phase_r, phase_nxt;
  logic [2:0] slot_r, slot_nxt;
  logic [2:0] term_r, term_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] last_slot;
  logic       push;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign last_slot = route_mode ? LAST_SLOT_PASS : LAST_SLOT_FULL;
  assign push      = (state_r == S_PUSH) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    slot_nxt  = slot_r;
    term_nxt  = term_r;

    cmd            = '0;
    cmd.mul_term   = term_r;
    cmd.mul_desc   = slot_desc(route_mode, slot_r);
    cmd.acc_term   = term_r - 3'd1;
    cmd.wb_desc    = slot_desc(route_mode, slot_r - 3'd1);
    cmd.capture    = in_valid && (state_r == S_IDLE);
    cmd.push_en    = push;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_GAIN;
          phase_nxt = 1'b0;
        end
      end
      S_GAIN: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = 1'b1;
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          cmd.mul_gain_r = 1'b1;
          cmd.tl_en      = 1'b1;
          state_nxt      = S_RUN;
          slot_nxt       = '0;
          term_nxt       = '0;
        end
      end
      S_RUN: begin
        cmd.mul_en    = (term_r != TERM_LAST);
        cmd.acc_en    = (term_r != TERM_A0);
        cmd.acc_first = (term_r == TERM_A1);
        cmd.wb_en     = (term_r == TERM_A0) && (slot_r != 3'd0);
        cmd.tr_en     = (term_r == TERM_A0) && (slot_r == 3'd0);
        cmd.pass_en   = (term_r == TERM_A0) && (slot_r == 3'd0) && route_mode;
        if (term_r == TERM_LAST) begin
          term_nxt = '0;
          slot_nxt = slot_r + 3'd1;
          if (slot_r == last_slot) begin
            state_nxt = S_WB;
          end
        end else begin
          term_nxt = term_r + 3'd1;
        end
      end
      S_WB: begin
        cmd.wb_en = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (push) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      slot_r      <= '0;
      term_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      slot_r      <= slot_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/subb_datapath.sv -----
// ----------------------------------------------------------------------------
// subb_datapath
// Shared multiplier, saturating accumulator, history words and result regs.
// ----------------------------------------------------------------------------
module subb_datapath import subb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  input  logic [GAIN_W-1:0]          gain,
  input  logic signed [SAMPLE_W-1:0] in_left,
  input  logic signed [SAMPLE_W-1:0] in_right,
  output logic signed [SAMPLE_W-1:0] res [NUM_CH]
);

  logic signed [SAMPLE_W-1:0] left_r, right_r;
  logic signed [SAMPLE_W-1:0] tl_r, tr_r;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [SAMPLE_W-1:0] pin_r  [HIST_D];
  logic signed [SAMPLE_W-1:0] pout_r [HIST_D];
  logic signed [SAMPLE_W-1:0] res_r  [NUM_CH];
  logic signed [SAMPLE_W-1:0] out_r  [NUM_CH];

  logic signed [SAMPLE_W-1:0] mul_a, mul_b;
  logic signed [SAMPLE_W-1:0] x_mul, x_wb;
  logic [3:0]                 midx0, midx1, widx0, widx1;
  logic signed [SAMPLE_W+1:0] term;
  logic signed [ACC_W:0]      sum;
  logic signed [ACC_W-1:0]    acc_base;
  logic signed [SAMPLE_W-1:0] y;

  assign midx0 = {cmd.mul_desc.ch, 1'b0};
  assign midx1 = {cmd.mul_desc.ch, 1'b1};
  assign widx0 = {cmd.wb_desc.ch, 1'b0};
  assign widx1 = {cmd.wb_desc.ch, 1'b1};
  assign x_mul = cmd.mul_desc.src_r ? tr_r : tl_r;
  assign x_wb  = cmd.wb_desc.src_r ? tr_r : tl_r;

  always_comb begin
    if (cmd.mul_gain) begin
      mul_a = cmd.mul_gain_r ? right_r : left_r;
      mul_b = $signed({1'b0, gain});
    end else begin
      mul_a = coef(cmd.mul_desc.set, cmd.mul_term);
      case (cmd.mul_term)
        TERM_A0: mul_b = x_mul;
        TERM_A1: mul_b = pin_r[midx0];
        TERM_A2: mul_b = pin_r[midx1];
        TERM_B1: mul_b = pout_r[midx0];
        TERM_B2: mul_b = pout_r[midx1];
        default: mul_b = '0;
      endcase
    end
    prod_nxt = mul_a * mul_b;
  end

  // floor(prod / 2^31) * 2, then saturating add or subtract
  always_comb begin
    term     = {prod_r[PROD_W-1:SAMPLE_W-1], 1'b0};
    acc_base = cmd.acc_first ? '0 : acc_r;
    if (cmd.acc_term == TERM_B1 || cmd.acc_term == TERM_B2) begin
      sum = (ACC_W+1)'(acc_base) - (ACC_W+1)'(term);
    end else begin
      sum = (ACC_W+1)'(acc_base) + (ACC_W+1)'(term);
    end
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_nxt = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_nxt = sum[ACC_W-1:0];
    end
  end

  always_comb begin
    if (acc_r[ACC_W-1:SAMPLE_W-1] == '0 || acc_r[ACC_W-1:SAMPLE_W-1] == '1) begin
      y = acc_r[SAMPLE_W-1:0];
    end else begin
      y = acc_r[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      left_r  <= in_left;
      right_r <= in_right;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.tl_en) begin
      tl_r <= prod_r[PROD_W-2:SAMPLE_W-1];
    end
    if (cmd.tr_en) begin
      tr_r <= prod_r[PROD_W-2:SAMPLE_W-1];
    end
    if (cmd.acc_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.pass_en) begin
      res_r[CH_LEFT] <= tl_r;
    end
    if (cmd.wb_en) begin
      res_r[cmd.wb_desc.ch] <= y;
    end
    if (cmd.push_en) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_D; i++) begin
        pin_r[i]  <= '0;
        pout_r[i] <= '0;
      end
    end else if (cmd.wb_en) begin
      pin_r[widx1]  <= pin_r[widx0];
      pin_r[widx0]  <= x_wb;
      pout_r[widx1] <= pout_r[widx0];
      pout_r[widx0] <= y;
    end
  end

  assign res = out_r;

endmodule

// ----- hdl/stereo_upmix_biquad_bank_unit.sv -----
// ----------------------------------------------------------------------------
// stereo_upmix_biquad_bank_unit
// Stereo to 5.1 upmixer: input gain and a bank of up to six direct-form-I biquads.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) transfers one Q1.31 stereo pair; the
// output channel (out_valid/out_ready) transfers six Q1.31 channel samples.
// One pair is worked on at a time with a single 32x32 multiplier: two gain
// multiplies, then five multiply-accumulate steps plus one drain step per
// filtered channel, then writeback. out_valid rises after the writeback, once
// the output register is free; a new pair is taken only when the block is
// idle again, after the last result has been pushed.
// The output register holds the finished result while the next pair is
// being computed; a stalled receiver only blocks completion of that next
// pair. cfg_we writes route_mode (index 0) or input_gain (index 1) at once;
// other indexes are ignored. The user must make writes only while the block
// is idle; the block itself does not enforce this.
// Synchronous reset clears all filter history, sets route_mode to 1 and
// input_gain to its default, and empties the output register.
// ----------------------------------------------------------------------------
module stereo_upmix_biquad_bank_unit import subb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_left_sample,
  input  logic signed [SAMPLE_W-1:0] in_right_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_left,
  output logic signed [SAMPLE_W-1:0] out_center,
  output logic signed [SAMPLE_W-1:0] out_right,
  output logic signed [SAMPLE_W-1:0] out_left_surround,
  output logic signed [SAMPLE_W-1:0] out_right_surround,
  output logic signed [SAMPLE_W-1:0] out_bass,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [GAIN_W-1:0]          cfg_data
);

  logic                       route_mode_r;
  logic [GAIN_W-1:0]          gain_r;
  dp_cmd_t                    cmd;
  logic signed [SAMPLE_W-1:0] res [NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_mode_r <= 1'b1;
      gain_r       <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROUTE_MODE: route_mode_r <= cfg_data[0];
        CFG_INPUT_GAIN: gain_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  subb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .route_mode (route_mode_r),
    .cmd        (cmd)
  );

  subb_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .gain     (gain_r),
    .in_left  (in_left_sample),
    .in_right (in_right_sample),
    .res      (res)
  );

  assign out_left           = res[CH_LEFT];
  assign out_center         = res[CH_CENTER];
  assign out_right          = res[CH_RIGHT];
  assign out_left_surround  = res[CH_LSUR];
  assign out_right_surround = res[CH_RSUR];
  assign out_bass           = res[CH_BASS];

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a pair is in progress");

  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without a pair in progress");

  a_push_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("block not idle after completing a pair");

endmodule
